// ----- rtl/dbtc_pkg.sv -----
package dbtc_pkg;

	localparam int BANDS = 4;
	localparam int MAX_POINTS = 16;
	localparam int BAND_W = $clog2(BANDS);
	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int ADDR_W = BAND_W + IDX_W;
	localparam int DEPTH = BANDS * MAX_POINTS;

	localparam logic signed [15:0] FLOOR_RESET = -16'sd19968;

	localparam logic [1:0] CMD_EVAL = 2'd0;
	localparam logic [1:0] CMD_INSERT = 2'd1;
	localparam logic [1:0] CMD_REMOVE = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	// memory access and datapath controls requested by the controller
	typedef struct packed {
		logic ld_item;
		logic rd;
		logic [ADDR_W-1:0] rd_addr;
		logic wr;
		logic [ADDR_W-1:0] wr_addr;
		logic wr_sel_new;
		logic ld_p1;
		logic shift_p;
		logic ld_anchor_floor;
		logic div_start;
		logic out_eval;
	} dp_cmd_t;

	typedef struct packed {
		logic signed [15:0] rd_x;
		logic div_busy;
	} dp_stat_t;

endpackage

// ----- rtl/dbtc_datapath.sv -----
module dbtc_datapath (
	input logic clk,
	input logic arst_n,
	input dbtc_pkg::dp_cmd_t cmd_i,
	output dbtc_pkg::dp_stat_t stat_o,
	input logic signed [15:0] level_db,
	input logic signed [15:0] point_y,
	input logic signed [15:0] floor_db,
	output logic signed [15:0] eval_db
);
	import dbtc_pkg::*;

	logic signed [15:0] x_mem [DEPTH];
	logic signed [15:0] y_mem [DEPTH];
	logic signed [15:0] rx_q, ry_q;
	logic signed [15:0] lvl_q, py_q;
	logic rd_vld_q;
	// p0 = lower point, p1 = upper point
	logic signed [15:0] x0_q, y0_q, x1_q, y1_q;
	logic signed [16:0] den;
	logic signed [33:0] num_q;
	logic signed [16:0] den_q;
	logic [33:0] rem_q, quo_q;
	logic [16:0] dmag_q;
	logic neg_q, zero_q;
	logic [5:0] dcnt_q;
	logic signed [16:0] dlvl, dy;
	logic [34:0] trial;
	logic signed [35:0] sum;
	logic signed [34:0] q_s;

	// hold the item fields for the whole command
	always_ff @(posedge clk) begin
		if (cmd_i.ld_item) begin
			lvl_q <= level_db;
			py_q <= point_y;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.rd) begin
			rx_q <= x_mem[cmd_i.rd_addr];
			ry_q <= y_mem[cmd_i.rd_addr];
		end
		if (cmd_i.wr) begin
			x_mem[cmd_i.wr_addr] <= cmd_i.wr_sel_new ? lvl_q : rx_q;
			y_mem[cmd_i.wr_addr] <= cmd_i.wr_sel_new ? py_q : ry_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.ld_p1) begin
			x1_q <= rx_q;
			y1_q <= ry_q;
		end else if (cmd_i.shift_p) begin
			x0_q <= x1_q;
			y0_q <= y1_q;
			x1_q <= rx_q;
			y1_q <= ry_q;
		end else if (cmd_i.ld_anchor_floor) begin
			x0_q <= floor_db;
			y0_q <= floor_db;
		end
	end

	assign dlvl = 17'(lvl_q) - 17'(x0_q);
	assign dy = 17'(y1_q) - 17'(y0_q);
	assign den = 17'(x1_q) - 17'(x0_q);

	// multiply once, then restoring divide one bit per cycle on magnitudes
	assign trial = {rem_q, quo_q[33]} - {18'd0, dmag_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dcnt_q <= '0;
		end else if (cmd_i.div_start) begin
			dcnt_q <= 6'd35;
		end else if (dcnt_q != '0) begin
			dcnt_q <= dcnt_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_i.div_start) begin
			num_q <= dlvl * dy;
			den_q <= den;
		end else if (dcnt_q == 6'd35) begin
			neg_q <= num_q[33] ^ den_q[16];
			zero_q <= (den_q == '0);
			quo_q <= num_q[33] ? 34'(-num_q) : 34'(num_q);
			dmag_q <= den_q[16] ? 17'(-den_q) : 17'(den_q);
			rem_q <= '0;
		end else if (dcnt_q != '0) begin
			if (!trial[34]) begin
				rem_q <= trial[33:0];
			end else begin
				rem_q <= {rem_q[32:0], quo_q[33]};
			end
			quo_q <= {quo_q[32:0], ~trial[34]};
		end
	end

	assign q_s = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});
	assign sum = zero_q ? 36'(y0_q) : 36'(y0_q) + 36'(q_s);

	always_ff @(posedge clk) begin
		if (cmd_i.out_eval) begin
			if (sum > 36'sd32767) eval_db <= 16'sh7fff;
			else if (sum < -36'sd32768) eval_db <= 16'sh8000;
			else eval_db <= sum[15:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) rd_vld_q <= 1'b0;
		else rd_vld_q <= cmd_i.rd;
	end

	assign stat_o.rd_x = rx_q;
	assign stat_o.div_busy = (dcnt_q != '0);

	a_div_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.div_start |=> dcnt_q == 6'd35) else $error("divider did not load");
	a_div_count: assert property (@(posedge clk) disable iff (!arst_n)
		(dcnt_q != '0 && !cmd_i.div_start) |=> dcnt_q == $past(dcnt_q) - 6'd1)
		else $error("divider count skipped");
	a_rd_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_i.rd |=> rd_vld_q) else $error("read flag lost");
endmodule

// ----- rtl/dbtc_ctrl.sv -----
module dbtc_ctrl (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] cmd,
	input logic [1:0] band,
	input logic signed [15:0] level_db,
	input logic [3:0] point_index,
	output dbtc_pkg::dp_cmd_t cmd_o,
	input dbtc_pkg::dp_stat_t stat_i,
	input logic signed [15:0] eval_db,
	output logic done,
	output logic signed [15:0] result_db,
	output logic [3:0] slot,
	output logic [1:0] status,
	output logic [4:0] point_count
);
	import dbtc_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_ESCAN = 4'd1;
	localparam logic [3:0] S_ECHK = 4'd2;
	localparam logic [3:0] S_EP1 = 4'd3;
	localparam logic [3:0] S_EP0 = 4'd4;
	localparam logic [3:0] S_DIV = 4'd5;
	localparam logic [3:0] S_EOUT = 4'd6;
	localparam logic [3:0] S_IRD = 4'd7;
	localparam logic [3:0] S_ICHK = 4'd8;
	localparam logic [3:0] S_RRD = 4'd9;
	localparam logic [3:0] S_RWR = 4'd10;
	localparam logic [3:0] S_DONE = 4'd11;
	localparam logic [3:0] S_EWAIT = 4'd12;
	localparam logic [3:0] S_DSTART = 4'd13;

	logic [3:0] state_q;
	logic [CNT_W-1:0] cnt_q [BANDS];
	logic [1:0] cmd_q, stat_q;
	logic [BAND_W-1:0] band_q;
	logic [CNT_W-1:0] n_q, k_q;
	logic [IDX_W-1:0] slot_q;
	logic [ADDR_W-1:0] base;
	logic [CNT_W-1:0] nb;
	logic signed [15:0] lvl_q;
	logic anc_q;

	assign nb = cnt_q[band[BAND_W-1:0]];
	assign busy = (state_q != S_IDLE);
	assign base = {band_q, {IDX_W{1'b0}}};

	always_comb begin
		cmd_o = '0;
		case (state_q)
			S_IDLE: cmd_o.ld_item = start;
			S_ESCAN, S_EWAIT, S_RRD: begin
				cmd_o.rd = 1'b1;
				cmd_o.rd_addr = base + ADDR_W'(k_q[IDX_W-1:0]);
			end
			S_IRD: begin
				cmd_o.rd = 1'b1;
				cmd_o.rd_addr = base + ADDR_W'(k_q[IDX_W-1:0] - IDX_W'(1));
			end
			S_EP1: begin
				cmd_o.ld_p1 = 1'b1;
				if (!anc_q) begin
					cmd_o.rd = 1'b1;
					cmd_o.rd_addr = base + ADDR_W'(k_q[IDX_W-1:0] + IDX_W'(1));
				end
			end
			S_EP0: begin
				if (anc_q) cmd_o.ld_anchor_floor = 1'b1;
				else cmd_o.shift_p = 1'b1;
			end
			S_DSTART: cmd_o.div_start = 1'b1;
			S_ICHK: begin
				if (k_q != '0 && !(stat_i.rd_x < lvl_q)) begin
					cmd_o.wr = 1'b1;
					cmd_o.wr_addr = base + ADDR_W'(k_q[IDX_W-1:0]);
				end else begin
					cmd_o.wr = 1'b1;
					cmd_o.wr_sel_new = 1'b1;
					cmd_o.wr_addr = base + ADDR_W'(k_q[IDX_W-1:0]);
				end
			end
			S_RWR: begin
				cmd_o.wr = 1'b1;
				cmd_o.wr_addr = base + ADDR_W'(k_q[IDX_W-1:0] - IDX_W'(1));
			end
			S_EOUT: cmd_o.out_eval = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i < BANDS; i++) cnt_q[i] <= '0;
			done <= 1'b0;
			k_q <= '0;
			n_q <= '0;
			cmd_q <= CMD_EVAL;
			stat_q <= ST_OK;
			slot_q <= '0;
			band_q <= '0;
			lvl_q <= '0;
			anc_q <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				S_IDLE: if (start) begin
					cmd_q <= cmd;
					band_q <= band[BAND_W-1:0];
					lvl_q <= level_db;
					n_q <= nb;
					stat_q <= ST_OK;
					slot_q <= '0;
					case (cmd)
						CMD_EVAL: begin
							if (nb == '0) state_q <= S_DONE;
							else begin
								k_q <= nb - CNT_W'(1);
								state_q <= S_ESCAN;
							end
						end
						CMD_INSERT: begin
							if (nb >= CNT_W'(MAX_POINTS)) begin
								stat_q <= ST_FULL;
								state_q <= S_DONE;
							end else if (nb == '0) begin
								k_q <= '0;
								state_q <= S_ICHK;
							end else begin
								k_q <= nb;
								state_q <= S_IRD;
							end
						end
						CMD_REMOVE: begin
							if (CNT_W'(point_index) >= nb) begin
								stat_q <= ST_RANGE;
								state_q <= S_DONE;
							end else begin
								k_q <= CNT_W'(point_index) + CNT_W'(1);
								state_q <= S_RRD;
							end
						end
						default: state_q <= S_DONE;
					endcase
				end
				// walk down for the last x <= level, leave k_q on the lower point (on point 0 when anchored to the floor)
				S_ESCAN: state_q <= S_ECHK;
				S_ECHK: begin
					if (n_q == CNT_W'(1)) begin
						anc_q <= 1'b1;
						k_q <= '0;
						state_q <= S_EWAIT;
					end else if (stat_i.rd_x <= lvl_q) begin
						anc_q <= 1'b0;
						if (k_q == n_q - CNT_W'(1)) k_q <= k_q - CNT_W'(1);
						state_q <= S_EWAIT;
					end else if (k_q == '0) begin
						anc_q <= 1'b1;
						state_q <= S_EWAIT;
					end else begin
						k_q <= k_q - CNT_W'(1);
						state_q <= S_ESCAN;
					end
				end
				// read point k_q, then the next point above it or the floor anchor below it
				S_EWAIT: state_q <= S_EP1;
				S_EP1: state_q <= S_EP0;
				S_EP0: state_q <= S_DSTART;
				S_DSTART: state_q <= S_DIV;
				S_DIV: if (!stat_i.div_busy) state_q <= S_EOUT;
				S_EOUT: state_q <= S_DONE;
				S_IRD: state_q <= S_ICHK;
				S_ICHK: begin
					if (k_q != '0 && !(stat_i.rd_x < lvl_q)) begin
						k_q <= k_q - CNT_W'(1);
						state_q <= S_IRD;
					end else begin
						slot_q <= k_q[IDX_W-1:0];
						cnt_q[band_q] <= n_q + CNT_W'(1);
						n_q <= n_q + CNT_W'(1);
						state_q <= S_DONE;
					end
				end
				S_RRD: begin
					if (k_q >= n_q) begin
						cnt_q[band_q] <= n_q - CNT_W'(1);
						n_q <= n_q - CNT_W'(1);
						state_q <= S_DONE;
					end else begin
						state_q <= S_RWR;
					end
				end
				S_RWR: begin
					k_q <= k_q + CNT_W'(1);
					state_q <= S_RRD;
				end
				S_DONE: begin
					done <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_comb begin
		result_db = '0;
		if (cmd_q == CMD_EVAL) result_db = (n_q == '0) ? lvl_q : eval_db;
	end
	assign slot = (cmd_q == CMD_INSERT && stat_q == ST_OK) ? slot_q : '0;
	assign status = stat_q;
	assign point_count = 5'(n_q);

	a_busy_done: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("strobe while busy");
	a_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy) else $error("item not taken");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		n_q <= CNT_W'(MAX_POINTS)) else $error("count overflow");
endmodule

// ----- rtl/db_transfer_curve_table_unit.sv -----
// Breakpoint transfer curve table, four bands of up to sixteen points.
// Command channel: an item (cmd, band, level_db, point_y, point_index) is
// taken at a clock edge where start is high and busy is low. busy stays
// high until the result is shown.
// Result channel: done pulses for one cycle with result_db, slot, status
// and point_count; the receiver cannot stall, and the result holds only
// until the next item is taken.
// Config channel: floor_db is written when cfg_valid and cfg_ready are
// high; cfg_ready is always high, write only while idle.
// Evaluate scans points down from the top of the table, then does the
// operand reads, the multiply, the serial divider (one quotient bit per
// cycle) and the output; insert compares points from the top and moves
// up each one not below level_db, remove moves those above point_index
// down. One item at a time: no new item is taken until the last is done.
// Reset clears the point counts and loads floor_db with -78.0 dB; the
// point memories are not cleared and only entries below the count are used.
module db_transfer_curve_table_unit (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [1:0] cmd,
	input logic [1:0] band,
	input logic signed [15:0] level_db,
	input logic signed [15:0] point_y,
	input logic [3:0] point_index,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic signed [15:0] cfg_data,
	output logic done,
	output logic signed [15:0] result_db,
	output logic [3:0] slot,
	output logic [1:0] status,
	output logic [4:0] point_count
);
	import dbtc_pkg::*;

	dp_cmd_t dp_cmd;
	dp_stat_t dp_stat;
	logic signed [15:0] floor_q, eval_db;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) floor_q <= FLOOR_RESET;
		else if (cfg_valid) floor_q <= cfg_data;
	end

	dbtc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.band(band), .level_db(level_db), .point_index(point_index),
		.cmd_o(dp_cmd), .stat_i(dp_stat), .eval_db(eval_db), .done(done),
		.result_db(result_db), .slot(slot), .status(status),
		.point_count(point_count)
	);

	dbtc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd_i(dp_cmd), .stat_o(dp_stat),
		.level_db(level_db), .point_y(point_y), .floor_db(floor_q),
		.eval_db(eval_db)
	);
endmodule
